### src/rpn_stack_evaluator_core_macros.svh
// Assertion helpers shared by the evaluator RTL.
// Each expects clk and rst_n in scope.
`ifndef RPN_STACK_EVALUATOR_CORE_MACROS_SVH
`define RPN_STACK_EVALUATOR_CORE_MACROS_SVH

// same-cycle implication
`define RSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rse_pkg.sv
`timescale 1ns / 1ps

package rse_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int ST_W    = 3;
    localparam int LEVEL_W = 5;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_FRAC_BITS   = 16;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_DIVZERO   = 3'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_SAT       = 3'd4;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

endpackage

### src/rpn_stack_evaluator_core.sv
`timescale 1ns / 1ps
`include "rpn_stack_evaluator_core_macros.svh"

// RPN evaluator on a signed fixed-point operand stack (FRAC_BITS fraction bits, Q16.16 by
// default). One command word is taken at a time and gives exactly one response word.
// Push, finish, unused opcodes and error cases pass from decode to write-back (a divide by
// zero also through the load state); add and subtract run through a bit-serial adder, one
// bit a cycle; multiply is a shift-add over the 32 multiplier bits; divide is a restoring
// divider giving one quotient bit a cycle over 32+FRAC_BITS bits (48 at Q16.16). A finished
// response sits in an output register until it is taken; the next command word is accepted
// and worked on meanwhile, and its response waits in write-back until that slot is free.
// The stack RAM needs no initialisation after reset.
module rpn_stack_evaluator_core #(
    parameter int STACK_DEPTH = rse_pkg::DEF_STACK_DEPTH,
    parameter int FRAC_BITS   = rse_pkg::DEF_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_stall,
    input  logic [rse_pkg::OP_W-1:0]             opcode,
    input  logic                                 finish,
    input  logic signed [rse_pkg::DATA_W-1:0]    value,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic signed [rse_pkg::DATA_W-1:0]    top_value,
    output logic [rse_pkg::ST_W-1:0]             status,
    output logic [rse_pkg::LEVEL_W-1:0]          stack_level,
    output logic                                 result_ready
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int NW  = 32 + FRAC_BITS;       // divider numerator / quotient width
    localparam int CW  = $clog2(NW);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_ADD,
        S_MUL,
        S_MFIN,
        S_DIV,
        S_DFIN,
        S_WB
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [rse_pkg::OP_W-1:0] op_reg, op_next;
    logic           fin_reg, fin_next;
    logic [31:0]    val_reg, val_next;

    logic [SPW-1:0] sp_reg, sp_next;
    logic [31:0]    top_reg, top_next;

    // shared serial datapath: x is the word shifted through the unit, y the other operand,
    // acc the running sum / accumulator / remainder
    logic [NW-1:0]  x_reg, x_next;
    logic [31:0]    y_reg, y_next;
    logic [32:0]    acc_reg, acc_next;
    logic           carry_reg, carry_next;
    logic           neg_reg, neg_next;

    logic [31:0]    res_val_reg, res_val_next;
    logic [rse_pkg::ST_W-1:0] res_st_reg, res_st_next;
    logic           res_rdy_reg, res_rdy_next;
    logic [SPW-1:0] sp_new_reg, sp_new_next;
    logic           wr_en_reg, wr_en_next;
    logic [AW-1:0]  wr_addr_reg, wr_addr_next;

    logic           rsp_valid_reg, rsp_valid_next;
    logic [31:0]    rsp_top_reg, rsp_top_next;
    logic [rse_pkg::ST_W-1:0] rsp_st_reg, rsp_st_next;
    logic [rse_pkg::LEVEL_W-1:0] rsp_lvl_reg, rsp_lvl_next;
    logic           rsp_rdy_reg, rsp_rdy_next;

    logic [31:0]    mem [STACK_DEPTH];
    logic [31:0]    rd_q;
    logic [SPW-1:0] sp_m2;
    logic [AW-1:0]  rd_addr;
    logic           mem_we;
    logic           out_free;

    logic           is_sub, xb, yb, s_bit, c_out, add_ovf;
    logic [31:0]    add_word, add_sat;
    logic [32:0]    y_ext, mul_addend, mul_sum;
    logic [63:0]    prod;
    logic [32-FRAC_BITS:0] prod_hi;
    logic           mul_fits;
    logic [32:0]    rem_sh;
    logic [33:0]    div_diff;
    logic           div_qb;
    logic           q_pos_ovf, q_neg_ovf;
    logic [31:0]    q_neg;
    logic [31:0]    mag_a, mag_b;
    logic [SPW+4:0] lvl_ext;

    assign cmd_stall    = (state_reg != S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign top_value    = rsp_top_reg;
    assign status       = rsp_st_reg;
    assign stack_level  = rsp_lvl_reg;
    assign result_ready = rsp_rdy_reg;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign sp_m2    = sp_reg - SPW'(2);
    assign rd_addr  = sp_m2[AW-1:0];
    assign mem_we   = (state_reg == S_WB) && out_free && wr_en_reg;
    assign lvl_ext  = (SPW + 5)'(sp_new_reg);

    // bit-serial add / subtract, LSB first
    assign is_sub   = (op_reg == rse_pkg::OP_SUB);
    assign xb       = x_reg[0];
    assign yb       = y_reg[0] ^ is_sub;
    assign s_bit    = xb ^ yb ^ carry_reg;
    assign c_out    = (xb & yb) | (xb & carry_reg) | (yb & carry_reg);
    assign add_ovf  = carry_reg ^ c_out;
    assign add_word = {s_bit, acc_reg[31:1]};
    assign add_sat  = neg_reg ? rse_pkg::Q_MIN : rse_pkg::Q_MAX;

    // shift-add multiply; the sign bit of the multiplier has negative weight
    assign y_ext      = {y_reg[31], y_reg};
    assign mul_addend = (cnt_reg == CW'(31)) ? (33'd0 - y_ext) : y_ext;
    assign mul_sum    = x_reg[0] ? (acc_reg + mul_addend) : acc_reg;
    assign prod       = {acc_reg[31:0], x_reg[31:0]};
    assign prod_hi    = prod[63:FRAC_BITS+31];
    assign mul_fits   = (&prod_hi) | ~(|prod_hi);

    // restoring divide on magnitudes
    assign rem_sh    = {acc_reg[31:0], x_reg[NW-1]};
    assign div_diff  = {1'b0, rem_sh} - {2'b00, y_reg};
    assign div_qb    = ~div_diff[33];
    assign q_pos_ovf = x_reg > NW'(rse_pkg::Q_MAX);
    assign q_neg_ovf = x_reg > NW'(rse_pkg::Q_MIN);
    assign q_neg     = 32'd0 - x_reg[31:0];

    assign mag_a = rd_q[31] ? (32'd0 - rd_q) : rd_q;
    assign mag_b = top_reg[31] ? (32'd0 - top_reg) : top_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        fin_next     = fin_reg;
        val_next     = val_reg;
        sp_next      = sp_reg;
        top_next     = top_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        acc_next     = acc_reg;
        carry_next   = carry_reg;
        neg_next     = neg_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        res_rdy_next = res_rdy_reg;
        sp_new_next  = sp_new_reg;
        wr_en_next   = wr_en_reg;
        wr_addr_next = wr_addr_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_top_next = rsp_top_reg;
        rsp_st_next  = rsp_st_reg;
        rsp_lvl_next = rsp_lvl_reg;
        rsp_rdy_next = rsp_rdy_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next    = opcode;
                    fin_next   = finish;
                    val_next   = value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_val_next = top_reg;
                res_st_next  = rse_pkg::ST_OK;
                res_rdy_next = 1'b0;
                sp_new_next  = sp_reg;
                wr_en_next   = 1'b0;
                state_next   = S_WB;
                if (fin_reg)
                begin
                    if (sp_reg == '0)
                        res_st_next = rse_pkg::ST_UNDERFLOW;
                    else
                    begin
                        res_rdy_next = 1'b1;
                        sp_new_next  = '0;
                    end
                end
                else if (op_reg == rse_pkg::OP_PUSH)
                begin
                    if (sp_reg == SPW'(STACK_DEPTH))
                        res_st_next = rse_pkg::ST_FULL;
                    else
                    begin
                        res_val_next = val_reg;
                        wr_en_next   = 1'b1;
                        wr_addr_next = sp_reg[AW-1:0];
                        sp_new_next  = sp_reg + SPW'(1);
                    end
                end
                else if (op_reg == rse_pkg::OP_ADD || op_reg == rse_pkg::OP_SUB ||
                         op_reg == rse_pkg::OP_MUL || op_reg == rse_pkg::OP_DIV)
                begin
                    if (sp_reg < SPW'(2))
                        res_st_next = rse_pkg::ST_UNDERFLOW;
                    else
                        state_next = S_LOAD;   // rd_q holds the deeper operand next cycle
                end
            end

            S_LOAD:
            begin
                wr_en_next   = 1'b1;
                wr_addr_next = rd_addr;
                sp_new_next  = sp_reg - SPW'(1);
                cnt_next     = '0;
                acc_next     = '0;
                case (op_reg)
                    rse_pkg::OP_MUL:
                    begin
                        x_next     = NW'(top_reg);
                        y_next     = rd_q;
                        state_next = S_MUL;
                    end
                    rse_pkg::OP_DIV:
                    begin
                        if (top_reg == 32'd0)
                        begin
                            res_st_next = rse_pkg::ST_DIVZERO;
                            wr_en_next  = 1'b0;
                            sp_new_next = sp_reg;
                            state_next  = S_WB;
                        end
                        else
                        begin
                            x_next     = NW'(mag_a) << FRAC_BITS;
                            y_next     = mag_b;
                            neg_next   = rd_q[31] ^ top_reg[31];
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        x_next     = NW'(rd_q);
                        y_next     = top_reg;
                        carry_next = is_sub;
                        neg_next   = rd_q[31];
                        state_next = S_ADD;
                    end
                endcase
            end

            S_ADD:
            begin
                x_next     = x_reg >> 1;
                y_next     = y_reg >> 1;
                carry_next = c_out;
                acc_next   = {1'b0, add_word};
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(31))
                begin
                    res_val_next = add_ovf ? add_sat : add_word;
                    res_st_next  = add_ovf ? rse_pkg::ST_SAT : rse_pkg::ST_OK;
                    state_next   = S_WB;
                end
            end

            S_MUL:
            begin
                acc_next       = {mul_sum[32], mul_sum[32:1]};
                x_next[31:0]   = {mul_sum[0], x_reg[31:1]};
                cnt_next       = cnt_reg + CW'(1);
                if (cnt_reg == CW'(31))
                    state_next = S_MFIN;
            end

            S_MFIN:
            begin
                if (mul_fits)
                begin
                    res_val_next = prod[FRAC_BITS+31:FRAC_BITS];
                    res_st_next  = rse_pkg::ST_OK;
                end
                else
                begin
                    res_val_next = prod[63] ? rse_pkg::Q_MIN : rse_pkg::Q_MAX;
                    res_st_next  = rse_pkg::ST_SAT;
                end
                state_next = S_WB;
            end

            S_DIV:
            begin
                acc_next = div_qb ? div_diff[32:0] : rem_sh;
                x_next   = {x_reg[NW-2:0], div_qb};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1))
                    state_next = S_DFIN;
            end

            S_DFIN:
            begin
                res_st_next = rse_pkg::ST_OK;
                if (neg_reg)
                begin
                    if (q_neg_ovf)
                    begin
                        res_val_next = rse_pkg::Q_MIN;
                        res_st_next  = rse_pkg::ST_SAT;
                    end
                    else
                        res_val_next = q_neg;
                end
                else
                begin
                    if (q_pos_ovf)
                    begin
                        res_val_next = rse_pkg::Q_MAX;
                        res_st_next  = rse_pkg::ST_SAT;
                    end
                    else
                        res_val_next = x_reg[31:0];
                end
                state_next = S_WB;
            end

            S_WB:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_top_next   = res_val_reg;
                    rsp_st_next    = res_st_reg;
                    rsp_lvl_next   = lvl_ext[4:0];
                    rsp_rdy_next   = res_rdy_reg;
                    sp_next        = sp_new_reg;
                    // a finish reports the old top and leaves an empty stack
                    top_next       = res_rdy_reg ? 32'd0 : res_val_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            op_reg        <= rse_pkg::OP_PUSH;
            fin_reg       <= 1'b0;
            val_reg       <= '0;
            sp_reg        <= '0;
            top_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            acc_reg       <= '0;
            carry_reg     <= 1'b0;
            neg_reg       <= 1'b0;
            res_val_reg   <= '0;
            res_st_reg    <= rse_pkg::ST_OK;
            res_rdy_reg   <= 1'b0;
            sp_new_reg    <= '0;
            wr_en_reg     <= 1'b0;
            wr_addr_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_top_reg   <= '0;
            rsp_st_reg    <= rse_pkg::ST_OK;
            rsp_lvl_reg   <= '0;
            rsp_rdy_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            fin_reg       <= fin_next;
            val_reg       <= val_next;
            sp_reg        <= sp_next;
            top_reg       <= top_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            acc_reg       <= acc_next;
            carry_reg     <= carry_next;
            neg_reg       <= neg_next;
            res_val_reg   <= res_val_next;
            res_st_reg    <= res_st_next;
            res_rdy_reg   <= res_rdy_next;
            sp_new_reg    <= sp_new_next;
            wr_en_reg     <= wr_en_next;
            wr_addr_reg   <= wr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_top_reg   <= rsp_top_next;
            rsp_st_reg    <= rsp_st_next;
            rsp_lvl_reg   <= rsp_lvl_next;
            rsp_rdy_reg   <= rsp_rdy_next;
        end
    end

    // operand stack RAM, registered read of the entry below the top
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr_reg] <= res_val_reg;
        rd_q <= mem[rd_addr];
    end

    `RSE_ASSERT_IMP(a_sp_bound, 1'b1, sp_reg <= SPW'(STACK_DEPTH), "stack pointer past depth")
    `RSE_ASSERT_IMP(a_empty_top, sp_reg == '0, top_reg == 32'd0, "empty stack with nonzero top")
    `RSE_ASSERT_IMP(a_final_ok, rsp_valid && result_ready, status == rse_pkg::ST_OK, "final bad")
    `RSE_ASSERT_IMP(a_final_empty, rsp_valid && result_ready, stack_level == '0, "kept stack")
    `RSE_ASSERT_NXT(a_accept_decode, cmd_valid && !cmd_stall, state_reg == S_DECODE, "no decode")

endmodule
